// ===== design/tlg_pkg.sv =====
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared widths, command codes and control/status types for the toroidal
// life generation step block.
// ----------------------------------------------------------------------------
package tlg_pkg;

    // Default grid size
    localparam int GRID_ROWS_DEF = 25;
    localparam int GRID_COLS_DEF = 80;

    // Payload field widths
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int EPOCH_W = 32;

    // Item command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture accepted beat
        logic clear_wr;    // write a zero row into bank 0
        logic cell_rd;     // read the addressed row of the live bank
        logic cell_wb;     // finish a cell write or read
        logic step_begin;  // count epoch, set up checks and counters
        logic win_issue;   // read the next window row and snapshot row
        logic win_shift;   // shift read row into the window
        logic row_commit;  // write new row, update snapshots and compares
        logic step_end;    // resolve halt, snapshot valid bits, swap banks
        logic cnt_clr;
        logic cnt_inc;
        logic out_load;    // place the result in the output register
    } tlg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             halted;
        logic             cnt_last;  // row counter at last row
        logic             pro_last;  // third window row fetched
        logic             out_free;  // output register can take a result
    } tlg_stat_t;

endpackage

// ===== design/tlg_in_if.sv =====
// ----------------------------------------------------------------------------
// tlg_in_if
// Item channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface tlg_in_if import tlg_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             alive;

    modport source (output valid, output cmd, output row, output col, output alive,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input alive,
                    output ready);

endinterface

// ===== design/tlg_out_if.sv =====
// ----------------------------------------------------------------------------
// tlg_out_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface tlg_out_if import tlg_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               cell_value;
    logic               halted;
    logic [EPOCH_W-1:0] epoch;

    modport source (output valid, output cell_value, output halted, output epoch,
                    input ready);
    modport sink   (input valid, input cell_value, input halted, input epoch,
                    output ready);

endinterface

// ===== design/toroidal_life_generation_step.sv =====
// ----------------------------------------------------------------------------
// toroidal_life_generation_step
// Wrap-around B3/S23 life grid with cell write/read and generation step,
// epoch count and period-two/three halt detection.
//
//   channel  | dir | beat fields
//   ---------+-----+-----------------------------------
//   item     | in  | cmd, row, col, alive
//   result   | out | cell_value, halted, epoch
//
// Steps of each item, from the accept cycle through the result load:
// Write/read: accept, decode, row read, merge/write, result load.
// Step: accept, decode, window prologue, row sweep, finish, result load; the
//   grid is swept row by row through the single read port of each grid bank.
// Halted step or no-op code: accept, decode, result load.
// After reset a clear pass writes GRID_ROWS zero rows before ready.
// A stalled result holds in the output register; the next beat is then taken
//   and processed up to its own result load.
// ----------------------------------------------------------------------------
module toroidal_life_generation_step import tlg_pkg::*; #(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    tlg_in_if.sink   item,
    tlg_out_if.source result
);

    tlg_cmd_t  cmd;
    tlg_stat_t stat;

    tlg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlg_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_cmd         (item.cmd),
        .in_row         (item.row),
        .in_col         (item.col),
        .in_alive       (item.alive),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_cell_value (result.cell_value),
        .out_halted     (result.halted),
        .out_epoch      (result.epoch)
    );

endmodule

// ===== design/tlg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlg_ctrl
// Sequencer: reset clear pass, cell access, and the row-by-row generation
// sweep with its window prologue.
// ----------------------------------------------------------------------------
module tlg_ctrl import tlg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tlg_stat_t stat,
    output tlg_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_DECODE  = 11'b000_0000_0100,
        S_CELL_RD = 11'b000_0000_1000,
        S_CELL_WB = 11'b000_0001_0000,
        S_PRO_A   = 11'b000_0010_0000,
        S_PRO_B   = 11'b000_0100_0000,
        S_ROW_A   = 11'b000_1000_0000,
        S_ROW_B   = 11'b001_0000_0000,
        S_FINISH  = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.item_cmd == CMD_WRITE || stat.item_cmd == CMD_READ)
                begin
                    state_next = S_CELL_RD;
                end
                else if (stat.item_cmd == CMD_STEP && !stat.halted)
                begin
                    cmd.step_begin = 1'b1;
                    cmd.cnt_clr    = 1'b1;
                    state_next     = S_PRO_A;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_CELL_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_CELL_WB;
            end
            S_CELL_WB:
            begin
                cmd.cell_wb = 1'b1;
                state_next  = S_OUT;
            end
            S_PRO_A:
            begin
                cmd.win_issue = 1'b1;
                state_next    = S_PRO_B;
            end
            S_PRO_B:
            begin
                cmd.win_shift = 1'b1;
                if (stat.pro_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_ROW_A;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_PRO_A;
                end
            end
            S_ROW_A:
            begin
                cmd.win_issue = 1'b1;
                state_next    = S_ROW_B;
            end
            S_ROW_B:
            begin
                cmd.row_commit = 1'b1;
                cmd.win_shift  = 1'b1;
                cmd.cnt_inc    = 1'b1;
                state_next     = stat.cnt_last ? S_FINISH : S_ROW_A;
            end
            S_FINISH:
            begin
                cmd.step_end = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Sweep commands only while no beat can be taken
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row_commit || cmd.clear_wr) |-> !in_ready)
        else $error("sweep overlaps item accept");

    // A step ends only right after the last row commit
    a_end_after_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_end |-> $past(cmd.row_commit && stat.cnt_last))
        else $error("step end without last row");

    // A result is loaded only from the output state, then the block is ready
    a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> in_ready)
        else $error("not ready after result load");

endmodule

// ===== design/tlg_datapath.sv =====
// ----------------------------------------------------------------------------
// tlg_datapath
// Grid banks, snapshot memories, three-row window with per-column rule
// lanes, epoch and halt state, and the output register.
// ----------------------------------------------------------------------------
module tlg_datapath import tlg_pkg::*; #(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlg_cmd_t           cmd,
    output tlg_stat_t          stat,
    input  logic [CMD_W-1:0]   in_cmd,
    input  logic [ROW_W-1:0]   in_row,
    input  logic [COL_W-1:0]   in_col,
    input  logic               in_alive,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_cell_value,
    output logic               out_halted,
    output logic [EPOCH_W-1:0] out_epoch
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);

    typedef logic [GRID_COLS-1:0] row_t;

    // Memories: two grid banks and the two snapshots, one row per word
    row_t bank0_mem [GRID_ROWS];
    row_t bank1_mem [GRID_ROWS];
    row_t snap2_mem [GRID_ROWS];
    row_t snap3_mem [GRID_ROWS];

    row_t bank0_rd_reg, bank1_rd_reg, snap2_rd_reg, snap3_rd_reg;

    // Item registers
    logic [CMD_W-1:0] item_cmd_reg;
    logic [ROW_W-1:0] item_row_reg;
    logic [COL_W-1:0] item_col_reg;
    logic             item_alive_reg;

    // Control state
    logic [RW-1:0]      cnt_reg;
    logic [RW-1:0]      rd_addr_reg;
    logic               bank_reg;
    logic [1:0]         snap_valid_reg;
    logic               halt_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [1:0]         mod3_reg;
    logic               chk2_reg, chk3_reg;
    logic               eq2_reg, eq3_reg;
    logic               out_valid_reg;

    // Payload registers
    row_t up_reg, mid_reg, dn_reg;
    logic value_reg;
    logic out_value_reg;
    logic out_halted_reg;
    logic [EPOCH_W-1:0] out_epoch_reg;

    logic [RW-1:0]      rd_addr;
    row_t               rd_word;
    row_t               cell_word;
    row_t               new_row;
    logic [RW-1:0]      item_row_idx;
    logic [CW-1:0]      item_col_idx;
    logic               in_range;
    logic [EPOCH_W-1:0] epoch_next;
    logic [1:0]         mod3_next;
    logic               wr0, wr1;
    logic [RW-1:0]      wr_addr;
    row_t               wr_data;

    assign item_row_idx = RW'(item_row_reg);
    assign item_col_idx = CW'(item_col_reg);
    assign in_range     = (int'(item_row_reg) < GRID_ROWS) && (int'(item_col_reg) < GRID_COLS);
    assign rd_addr      = cmd.cell_rd ? item_row_idx : rd_addr_reg;
    assign rd_word      = bank_reg ? bank1_rd_reg : bank0_rd_reg;

    // Cell write merges the new bit into the row just read
    always_comb
    begin
        cell_word               = rd_word;
        cell_word[item_col_idx] = item_alive_reg;
    end

    // One rule lane per column; neighbors wrap at the grid edges
    always_comb
    begin
        int lf;
        int rt;
        logic [3:0] n;
        new_row = '0;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            lf = (c == 0) ? GRID_COLS - 1 : c - 1;
            rt = (c == GRID_COLS - 1) ? 0 : c + 1;
            n  = 4'(up_reg[lf]) + 4'(up_reg[c]) + 4'(up_reg[rt]) +
                 4'(mid_reg[lf]) + 4'(mid_reg[rt]) +
                 4'(dn_reg[lf]) + 4'(dn_reg[c]) + 4'(dn_reg[rt]);
            new_row[c] = (n == 4'd3) || (mid_reg[c] && n == 4'd2);
        end
    end

    // Bank write port select
    always_comb
    begin
        wr0     = 1'b0;
        wr1     = 1'b0;
        wr_addr = cnt_reg;
        wr_data = new_row;
        if (cmd.clear_wr)
        begin
            wr0     = 1'b1;
            wr_data = '0;
        end
        else if (cmd.cell_wb)
        begin
            if (item_cmd_reg == CMD_WRITE && in_range)
            begin
                wr0 = !bank_reg;
                wr1 = bank_reg;
            end
            wr_addr = item_row_idx;
            wr_data = cell_word;
        end
        else if (cmd.row_commit)
        begin
            wr0 = bank_reg;
            wr1 = !bank_reg;
        end
    end

    // Grid banks
    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (wr1)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
        bank0_rd_reg <= bank0_mem[rd_addr];
        bank1_rd_reg <= bank1_mem[rd_addr];
    end

    // Snapshots, read and refreshed row by row during the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.row_commit && chk2_reg)
        begin
            snap2_mem[cnt_reg] <= new_row;
        end
        if (cmd.row_commit && chk3_reg)
        begin
            snap3_mem[cnt_reg] <= new_row;
        end
        snap2_rd_reg <= snap2_mem[cnt_reg];
        snap3_rd_reg <= snap3_mem[cnt_reg];
    end

    // Saturating epoch with a running remainder by three
    always_comb
    begin
        epoch_next = epoch_reg;
        mod3_next  = mod3_reg;
        if (epoch_reg != '1)
        begin
            epoch_next = epoch_reg + 1'b1;
            mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rd_addr_reg    <= '0;
            bank_reg       <= 1'b0;
            snap_valid_reg <= 2'b00;
            halt_reg       <= 1'b0;
            epoch_reg      <= '0;
            mod3_reg       <= 2'd0;
            chk2_reg       <= 1'b0;
            chk3_reg       <= 1'b0;
            eq2_reg        <= 1'b0;
            eq3_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= (cnt_reg == ROW_LAST) ? '0 : cnt_reg + 1'b1;
            end
            if (cmd.step_begin)
            begin
                rd_addr_reg <= ROW_LAST;
                epoch_reg   <= epoch_next;
                mod3_reg    <= mod3_next;
                chk3_reg    <= (mod3_next == 2'd0);
                chk2_reg    <= !epoch_next[0];
                eq2_reg     <= 1'b1;
                eq3_reg     <= 1'b1;
            end
            else if (cmd.win_issue)
            begin
                rd_addr_reg <= (rd_addr_reg == ROW_LAST) ? '0 : rd_addr_reg + 1'b1;
            end
            if (cmd.row_commit)
            begin
                eq2_reg <= eq2_reg && (new_row == snap2_rd_reg);
                eq3_reg <= eq3_reg && (new_row == snap3_rd_reg);
            end
            if (cmd.step_end)
            begin
                halt_reg <= halt_reg
                            || (chk3_reg && snap_valid_reg[1] && eq3_reg)
                            || (chk2_reg && snap_valid_reg[0] && eq2_reg);
                snap_valid_reg <= snap_valid_reg | {chk3_reg, chk2_reg};
                bank_reg       <= !bank_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item, window and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg   <= in_cmd;
            item_row_reg   <= in_row;
            item_col_reg   <= in_col;
            item_alive_reg <= in_alive;
            value_reg      <= 1'b0;
        end
        if (cmd.cell_wb)
        begin
            value_reg <= (item_cmd_reg == CMD_READ) && in_range && rd_word[item_col_idx];
        end
        if (cmd.win_shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn_reg;
            dn_reg  <= rd_word;
        end
        // Result fields are frozen so a held beat survives the next item
        if (cmd.out_load)
        begin
            out_value_reg  <= value_reg;
            out_halted_reg <= halt_reg;
            out_epoch_reg  <= epoch_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_cell_value = out_value_reg;
    assign out_halted     = out_halted_reg;
    assign out_epoch      = out_epoch_reg;

    assign stat.item_cmd = item_cmd_reg;
    assign stat.halted   = halt_reg;
    assign stat.cnt_last = (cnt_reg == ROW_LAST);
    assign stat.pro_last = (cnt_reg == RW'(2));
    assign stat.out_free = !out_valid_reg || out_ready;

    // Halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    // Halt rises only at the end of a step
    a_halt_at_step_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halt_reg) |-> $past(cmd.step_end))
        else $error("halt set outside step end");

    // Epoch moves only on a step start
    a_epoch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.step_begin |=> $stable(epoch_reg))
        else $error("epoch changed outside step");

    // Remainder register never holds three
    a_mod3_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod3_reg != 2'd3)
        else $error("bad epoch remainder");

endmodule

// ===== test/tb_toroidal_life_generation_step.sv =====
// ----------------------------------------------------------------------------
// tb_toroidal_life_generation_step
// Self-checking bench for the wrap-around life grid. A behavioral copy of the
// grid, the snapshots, the epoch and the halt flag predicts every result beat.
// Directed cell accesses, gliders and random soups are sent under several
// idle/stall mixes. One long receiver hold-off; every test ends in a full drain.
// ----------------------------------------------------------------------------
module tb_toroidal_life_generation_step;
    import tlg_pkg::*;

    localparam int ROWS = GRID_ROWS_DEF;
    localparam int COLS = GRID_COLS_DEF;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * ROWS + 20;

    typedef struct packed {
        logic             cell_value;
        logic             halted;
        logic [EPOCH_W-1:0] epoch;
    } life_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tlg_in_if  item_ch ();
    tlg_out_if result_ch ();

    toroidal_life_generation_step uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    always #5 clk = ~clk;

    // Predicted state of the block
    logic [COLS-1:0] grid [ROWS];
    logic [COLS-1:0] snap_two [ROWS];
    logic [COLS-1:0] snap_three [ROWS];
    logic            snap_two_ok;
    logic            snap_three_ok;
    logic [EPOCH_W-1:0] epoch_cnt;
    logic            halt_seen;

    life_result_t pending_results [$];
    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  steps_sent = 0;
    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;

    // Advance the predicted grid by one generation
    task automatic next_generation();
        logic [COLS-1:0] prev [ROWS];
        int up, dn, lf, rt, n;
        prev = grid;
        for (int r = 0; r < ROWS; r++)
        begin
            up = (r + ROWS - 1) % ROWS;
            dn = (r + 1) % ROWS;
            for (int c = 0; c < COLS; c++)
            begin
                lf = (c + COLS - 1) % COLS;
                rt = (c + 1) % COLS;
                n = prev[up][lf] + prev[up][c] + prev[up][rt] + prev[r][lf]
                  + prev[r][rt] + prev[dn][lf] + prev[dn][c] + prev[dn][rt];
                grid[r][c] = prev[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
    endtask

    // Work out the result beat for one accepted item
    task automatic predict_life(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col, input logic alive);
        life_result_t res;
        logic in_range;
        in_range = (row < ROWS) && (col < COLS);
        res.cell_value = 1'b0;
        case (cmd)
            CMD_WRITE: if (in_range) grid[row][col] = alive;
            CMD_READ:  if (in_range) res.cell_value = grid[row][col];
            CMD_STEP:
            begin
                if (!halt_seen)
                begin
                    if (epoch_cnt != '1) epoch_cnt++;
                    next_generation();
                    // three-epoch check first, then two-epoch
                    if (epoch_cnt % 3 == 0)
                    begin
                        if (snap_three_ok && snap_three == grid) halt_seen = 1'b1;
                        snap_three = grid;
                        snap_three_ok = 1'b1;
                    end
                    if (epoch_cnt % 2 == 0)
                    begin
                        if (snap_two_ok && snap_two == grid) halt_seen = 1'b1;
                        snap_two = grid;
                        snap_two_ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.halted = halt_seen;
        res.epoch = epoch_cnt;
        pending_results.push_back(res);
    endtask

    // Offer one beat; valid stays high after acceptance unless the next call idles
    task automatic send_beat(input int cmd_i, input int row_i, input int col_i,
                             input int alive_i);
        logic [CMD_W-1:0] cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             alive;
        cmd = CMD_W'(cmd_i);
        row = ROW_W'(row_i);
        col = COL_W'(col_i);
        alive = 1'(alive_i);
        if ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge clk);
        end
        item_ch.cmd = cmd;
        item_ch.row = row;
        item_ch.col = col;
        item_ch.alive = alive;
        item_ch.valid = 1'b1;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        predict_life(cmd, row, col, alive);
        beats_in++;
        if (cmd == CMD_STEP) steps_sent++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        item_ch.valid = 1'b0;
    endtask

    task automatic wait_all_results();
        stop_sending();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic place_glider(input int r0, input int c0);
        send_beat(CMD_WRITE, r0 % ROWS, (c0 + 1) % COLS, 1'b1);
        send_beat(CMD_WRITE, (r0 + 1) % ROWS, (c0 + 2) % COLS, 1'b1);
        send_beat(CMD_WRITE, (r0 + 2) % ROWS, c0 % COLS, 1'b1);
        send_beat(CMD_WRITE, (r0 + 2) % ROWS, (c0 + 1) % COLS, 1'b1);
        send_beat(CMD_WRITE, (r0 + 2) % ROWS, (c0 + 2) % COLS, 1'b1);
    endtask

    // Corner cells, out-of-range addresses, no-op code, glider over the wrap
    task automatic test_directed();
        send_beat(CMD_READ, 0, 0, 1'b0);
        send_beat(CMD_WRITE, 0, 0, 1'b1);
        send_beat(CMD_READ, 0, 0, 1'b0);
        send_beat(CMD_WRITE, ROWS - 1, COLS - 1, 1'b1);
        send_beat(CMD_READ, ROWS - 1, COLS - 1, 1'b1);
        send_beat(CMD_WRITE, 31, 127, 1'b1);
        send_beat(CMD_READ, 31, 127, 1'b0);
        send_beat(CMD_WRITE, ROWS, 3, 1'b1);
        send_beat(CMD_READ, 3, COLS, 1'b0);
        send_beat(CMD_NOP, 5, 5, 1'b1);
        send_beat(CMD_WRITE, 0, 0, 1'b0);
        send_beat(CMD_WRITE, ROWS - 1, COLS - 1, 1'b0);
        // glider straddling both edges keeps the grid from repeating soon
        place_glider(ROWS - 1, COLS - 1);
        send_beat(CMD_STEP, 0, 0, 1'b0);
        send_beat(CMD_READ, 0, 0, 1'b0);
        send_beat(CMD_STEP, 0, 0, 1'b0);
        send_beat(CMD_STEP, 0, 0, 1'b0);
        send_beat(CMD_READ, 1, 1, 1'b0);
        send_beat(CMD_STEP, 0, 0, 1'b0);
        send_beat(CMD_NOP, 31, 127, 1'b0);
        wait_all_results();
    endtask

    // Mostly in-range writes, reads and steps, with some raw noise
    task automatic test_random(input int count, input int idle, input int stall);
        int pick;
        src_idle_pct = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_beat($urandom, $urandom, $urandom, $urandom);
            else if (pick < 30)
                send_beat(CMD_STEP, $urandom, $urandom, $urandom);
            else if (pick < 60)
                send_beat(CMD_READ, $urandom_range(ROWS - 1), $urandom_range(COLS - 1), 1'b0);
            else if (pick < 63)
                place_glider($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
            else
                send_beat(CMD_WRITE, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                          $urandom);
        end
        wait_all_results();
    endtask

    // Receiver holds off while items keep coming, so the block backs up
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        @(negedge clk);
        hold_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_beat(i % 3 == 0 ? CMD_STEP : CMD_READ, $urandom_range(ROWS - 1),
                      $urandom_range(COLS - 1), 1'b0);
        wait_all_results();
    endtask

    // Step until a repeat or 60 steps, then check that steps are ignored if halted
    task automatic test_halt();
        src_idle_pct = 10;
        snk_stall_pct = 10;
        for (int i = 0; i < 60 && !halt_seen; i++)
        begin
            if (i % 4 == 0)
                send_beat(CMD_WRITE, $urandom_range(ROWS - 1), $urandom_range(COLS - 1), 1'b0);
            send_beat(CMD_STEP, 0, 0, 1'b0);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_beat(CMD_STEP, 0, 0, 1'b0);
            send_beat(CMD_READ, $urandom_range(ROWS - 1), $urandom_range(COLS - 1), 1'b0);
            send_beat(CMD_WRITE, $urandom_range(ROWS - 1), $urandom_range(COLS - 1), 1'b1);
        end
        wait_all_results();
    endtask

    // Receiver ready: random stalls, or a counted hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        life_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            beats_out++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat cell=%0b halted=%0b epoch=%0d", $time,
                         result_ch.cell_value, result_ch.halted, result_ch.epoch);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.cell_value !== want.cell_value)
                begin
                    $display("%0t: cell_value expected %0b actual %0b", $time,
                             want.cell_value, result_ch.cell_value);
                    errors++;
                end
                if (result_ch.halted !== want.halted)
                begin
                    $display("%0t: halted expected %0b actual %0b", $time,
                             want.halted, result_ch.halted);
                    errors++;
                end
                if (result_ch.epoch !== want.epoch)
                begin
                    $display("%0t: epoch expected %0d actual %0d", $time,
                             want.epoch, result_ch.epoch);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("toroidal_life_generation_step test failed");
            $finish;
        end
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_WRITE;
        item_ch.row = '0;
        item_ch.col = '0;
        item_ch.alive = 1'b0;
        result_ch.ready = 1'b0;
        for (int r = 0; r < ROWS; r++)
        begin
            grid[r] = '0;
            snap_two[r] = '0;
            snap_three[r] = '0;
        end
        snap_two_ok = 1'b0;
        snap_three_ok = 1'b0;
        epoch_cnt = '0;
        halt_seen = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(45, 0, 0);
        test_random(45, 65, 0);
        test_random(45, 0, 65);
        test_random(45, 28, 28);
        test_backpressure();
        test_halt();

        $display("Covered %0d item beats and %0d result beats, %0d steps, final epoch %0d",
                 beats_in, beats_out, steps_sent, epoch_cnt);
        $display("Halt reached: %0b; idle/stall mixes and a long receiver hold-off run",
                 halt_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("toroidal_life_generation_step test passed");
        else
            $display("toroidal_life_generation_step test failed");
        $finish;
    end

endmodule
